// ===== rtl/sqa_pkg.sv =====
// Shared constants, codes and request/response types of the shift queue with aggregates.
package sqa_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int WORD_WIDTH  = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W       = WORD_WIDTH + IDX_W;

	typedef enum logic [2:0] {
		CMD_ENQUEUE = 3'd0,
		CMD_DEQUEUE = 3'd1,
		CMD_CLEAR   = 3'd2,
		CMD_SEARCH  = 3'd3,
		CMD_READ    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic        [2:0]            command;
		logic signed [WORD_WIDTH-1:0] new_value;
		logic        [COUNT_W-1:0]    position;
	} req_t;

	typedef struct packed {
		logic        [1:0]            status;
		logic signed [WORD_WIDTH-1:0] word_out;
		logic                         found;
		logic        [COUNT_W-1:0]    first_match_res;
		logic        [COUNT_W-1:0]    match_count;
		logic        [COUNT_W-1:0]    entry_total;
		logic signed [SUM_W-1:0]      sum_of_entries;
		logic signed [WORD_WIDTH-1:0] smallest;
		logic signed [WORD_WIDTH-1:0] largest;
	} rsp_t;

	typedef struct packed {
		logic shift;
		logic scan_load;
		logic scan_shift;
	} cell_ctl_t;

endpackage

// ===== rtl/sqa_cell.sv =====
// One queue cell: a stored word plus a scan copy, both handed down to the lower neighbour.
module sqa_cell (
	input  logic                                 clk,
	input  sqa_pkg::cell_ctl_t                   ctl,
	input  logic                                 wr,
	input  logic signed [sqa_pkg::WORD_WIDTH-1:0] new_value,
	input  logic signed [sqa_pkg::WORD_WIDTH-1:0] next_data,
	input  logic signed [sqa_pkg::WORD_WIDTH-1:0] next_scan,
	output logic signed [sqa_pkg::WORD_WIDTH-1:0] data,
	output logic signed [sqa_pkg::WORD_WIDTH-1:0] scan
);
	import sqa_pkg::*;

	logic signed [WORD_WIDTH-1:0] data_q;
	logic signed [WORD_WIDTH-1:0] scan_q;
	logic signed [WORD_WIDTH-1:0] data_next;

	// take the upper neighbour on a shift, the new word on a write
	always_comb begin
		data_next = data_q;
		if (ctl.shift) begin
			data_next = next_data;
		end
		if (wr) begin
			data_next = new_value;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
		if (ctl.scan_load) begin
			scan_q <= data_next;
		end else if (ctl.scan_shift) begin
			scan_q <= next_scan;
		end
	end

	assign data = data_q;
	assign scan = scan_q;

endmodule

// ===== rtl/shift_queue_with_aggregates.sv =====
// Top level: command sequencer, occupancy count and scan accumulators over a chain of cells.
// Sequence: a request taken in idle is applied (S_EXEC), then each stored entry is scanned
//   in turn (S_SCAN, skipped when the queue is left empty), then the result is shown (S_DONE).
// One request at a time: busy stays high from acceptance through the result strobe
//   and the next request is taken only once the sequencer is back in idle.
// The receiver cannot stall: done is high for exactly one cycle with result valid.
// Reset clears the sequencer and the entry count; cell contents stay undefined until written.
module shift_queue_with_aggregates (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sqa_pkg::req_t request,
	output logic          busy,
	output logic          done,
	output sqa_pkg::rsp_t result
);
	import sqa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                       state_q;
	req_t                         req_q;
	logic [COUNT_W-1:0]           count_q;
	logic [COUNT_W-1:0]           count_next;
	logic [1:0]                   status_q;
	logic signed [WORD_WIDTH-1:0] word_q;
	logic [IDX_W-1:0]             idx_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic signed [WORD_WIDTH-1:0] lo_q;
	logic signed [WORD_WIDTH-1:0] hi_q;
	logic [COUNT_W-1:0]           match_q;
	logic [COUNT_W-1:0]           first_q;
	logic                         hit_q;

	// Cell chain wiring: element i feeds from element i+1, the top cell from zero.
	logic signed [WORD_WIDTH-1:0] data_w [QUEUE_DEPTH];
	logic signed [WORD_WIDTH-1:0] scan_w [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]       wr_vec;
	cell_ctl_t                    ctl;

	logic                         enq_ok;
	logic                         deq_ok;
	logic signed [WORD_WIDTH-1:0] head_scan;
	logic [COUNT_W-1:0]           scan_pos;
	logic                         scan_last;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// Command decode for the apply cycle.
	assign enq_ok = (state_q == S_EXEC) && (req_q.command == CMD_ENQUEUE)
		&& (count_q != COUNT_W'(QUEUE_DEPTH));
	assign deq_ok = (state_q == S_EXEC) && (req_q.command == CMD_DEQUEUE)
		&& (count_q != '0);

	always_comb begin
		count_next = count_q;
		if (enq_ok) begin
			count_next = count_q + COUNT_W'(1);
		end else if (deq_ok) begin
			count_next = count_q - COUNT_W'(1);
		end else if ((state_q == S_EXEC) && (req_q.command == CMD_CLEAR)) begin
			count_next = '0;
		end
	end

	// Shift the whole chain on dequeue; snapshot the updated words into the scan
	// copies in the same cycle, then walk them down towards cell 0.
	assign ctl.shift      = deq_ok;
	assign ctl.scan_load  = (state_q == S_EXEC);
	assign ctl.scan_shift = (state_q == S_SCAN);

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic signed [WORD_WIDTH-1:0] nd;
			logic signed [WORD_WIDTH-1:0] ns;

			// enqueue writes the first free cell
			assign wr_vec[gi] = enq_ok && (count_q == COUNT_W'(gi));

			if (gi == QUEUE_DEPTH - 1) begin : g_top
				assign nd = '0;
				assign ns = '0;
			end else begin : g_mid
				assign nd = data_w[gi+1];
				assign ns = scan_w[gi+1];
			end

			sqa_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.wr        (wr_vec[gi]),
				.new_value (req_q.new_value),
				.next_data (nd),
				.next_scan (ns),
				.data      (data_w[gi]),
				.scan      (scan_w[gi])
			);
		end
	endgenerate

	// The entry under scan always sits in cell 0's scan copy.
	assign head_scan = scan_w[0];
	assign scan_pos  = COUNT_W'(idx_q) + COUNT_W'(1);
	assign scan_last = (scan_pos == count_q);

	// Sequencer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			count_q <= count_next;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// nothing stored: report the empty aggregates at once
					state_q <= (count_next == '0) ? S_DONE : S_SCAN;
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture, command outcome and scan accumulators (payload, no reset).
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			req_q <= request;
		end
		if (state_q == S_EXEC) begin
			status_q <= ST_OK;
			word_q   <= '0;
			if ((req_q.command == CMD_ENQUEUE) && !enq_ok) begin
				status_q <= ST_FULL;
			end
			if (req_q.command == CMD_DEQUEUE) begin
				if (deq_ok) begin
					word_q <= data_w[0];
				end else begin
					status_q <= ST_EMPTY;
				end
			end
			idx_q   <= '0;
			sum_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			match_q <= '0;
			first_q <= '0;
			hit_q   <= 1'b0;
		end
		if (state_q == S_SCAN) begin
			sum_q <= sum_q + SUM_W'(head_scan);
			if ((idx_q == '0) || (head_scan < lo_q)) begin
				lo_q <= head_scan;
			end
			if ((idx_q == '0) || (head_scan > hi_q)) begin
				hi_q <= head_scan;
			end
			if ((req_q.command == CMD_SEARCH) && (head_scan == req_q.new_value)) begin
				match_q <= match_q + COUNT_W'(1);
				if (match_q == '0) begin
					first_q <= scan_pos;
				end
			end
			if ((req_q.command == CMD_READ) && (scan_pos == req_q.position)) begin
				word_q <= head_scan;
				hit_q  <= 1'b1;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Assemble the result; valid only while done is high.
	always_comb begin
		result                 = '0;
		result.status          = status_q;
		result.word_out        = word_q;
		result.first_match_res = first_q;
		result.match_count     = match_q;
		result.entry_total     = count_q;
		result.sum_of_entries  = sum_q;
		result.smallest        = lo_q;
		result.largest         = hi_q;
		if (req_q.command == CMD_SEARCH) begin
			result.found  = (match_q != '0);
			result.status = (match_q != '0) ? ST_OK : ST_NOT_FOUND;
		end
		if (req_q.command == CMD_READ) begin
			result.status = hit_q ? ST_OK : ST_NOT_FOUND;
		end
	end

endmodule
